>>> rtl/bud_pkg.sv
// ----------------------------------------------------------------------------
// bud_pkg: shared constants and types for the buddy allocator
// Sizes of the buddy tree, the live-block table, the status codes and the request codes.
// ----------------------------------------------------------------------------
package bud_pkg;
  localparam int MemUnits  = 1024;
  localparam int MaxLive   = 64;
  localparam int IdBits    = 16;
  localparam int AddrW     = $clog2(MemUnits);
  localparam int CapW      = AddrW + 1;
  localparam int NodeW     = AddrW + 1;
  localparam int TreeSlots = 2 * MemUnits;
  localparam int LiveW     = $clog2(MaxLive);
  localparam int CntW      = LiveW + 1;
  localparam int LvlW      = $clog2(AddrW + 1);

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StMoved    = 3'd3;
  localparam logic [2:0] StMoveFail = 3'd4;

  localparam logic [1:0] ReqAlloc  = 2'd0;
  localparam logic [1:0] ReqFree   = 2'd1;
  localparam logic [1:0] ReqResize = 2'd2;

  typedef struct packed {
    logic [IdBits-1:0] id;
    logic [AddrW-1:0]  start;
    logic [CapW-1:0]   cap;
  } entry_t;
endpackage

>>> rtl/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator: buddy memory allocator with id table
// Allocate, free and resize power-of-two blocks over MemUnits units.
// ----------------------------------------------------------------------------
// One request is taken when start_i is high and busy_o is low; exactly one
// result follows, held on the result ports for one cycle with done_o high.
// The receiver cannot stall the result. The block is sequential: a request
// walks the free map (a memory, one node read at a time) and the live table
// (one entry at a time); busy_o stays high until the result is given. The
// best-fit search scans tree nodes one at a time, up to 2*MemUnits reads;
// table search and compaction take up to MaxLive steps each.
// After reset a clearing pass zeroes the free map and sets the root; busy_o
// stays high during it.
module buddy_allocator
  import bud_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        req_type_i,
  input  logic [15:0]       req_size_i,
  input  logic [15:0]       req_id_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [15:0]       block_id_o,
  output logic [9:0]        base_addr_o,
  output logic [10:0]       capacity_o
);
  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_FIND  = 5'd2;  // table lookup, one entry at a time
  localparam logic [4:0] S_FINDW = 5'd3;
  localparam logic [4:0] S_SHIFT = 5'd4;  // compact table after removal
  localparam logic [4:0] S_SHIFW = 5'd5;
  localparam logic [4:0] S_MSET  = 5'd6;  // merge: set node, read buddy
  localparam logic [4:0] S_MCHK  = 5'd7;
  localparam logic [4:0] S_GRAB  = 5'd8;  // allocate start
  localparam logic [4:0] S_SRCH  = 5'd9;  // scan free map
  localparam logic [4:0] S_SRCHW = 5'd10;
  localparam logic [4:0] S_SPLIT = 5'd11;
  localparam logic [4:0] S_DONE  = 5'd12;
  localparam logic [4:0] S_MCLR  = 5'd13; // merge: clear the child

  logic [4:0] state_q, state_d;

  // free map memory
  logic             fm_mem [TreeSlots];
  logic             fm_we;
  logic [NodeW-1:0] fm_wa, fm_ra;
  logic             fm_wd, fm_rd_q;
  always_ff @(posedge clk_i) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd_q <= fm_mem[fm_ra];
  end

  // live table memory
  entry_t           tb_mem [MaxLive];
  logic             tb_we;
  logic [LiveW-1:0] tb_wa, tb_ra;
  entry_t           tb_wd, tb_rd_q;
  always_ff @(posedge clk_i) begin
    if (tb_we) tb_mem[tb_wa] <= tb_wd;
    tb_rd_q <= tb_mem[tb_ra];
  end

  logic [1:0]        type_q, type_d;
  logic [16:0]       size_q, size_d;
  logic [IdBits-1:0] rid_q, rid_d, idc_q, idc_d;
  logic [CntW-1:0]   live_q, live_d, idx_q, idx_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [NodeW:0]    end_q, end_d;
  logic [CapW-1:0]   need_q, need_d, blk_q, blk_d;
  logic [2:0]        st_q, st_d;
  logic [IdBits-1:0] bid_q, bid_d;
  logic [AddrW-1:0]  sa_q, sa_d;
  logic [CapW-1:0]   cap_q, cap_d;

  localparam logic [CapW-1:0] MemCap = CapW'(MemUnits);

  // node index of a block: MemUnits/cap + start/cap, cap a power of two
  function automatic logic [NodeW-1:0] node_of(logic [AddrW-1:0] s, logic [CapW-1:0] c);
    logic [NodeW-1:0] n;
    n = '0;
    for (int b = 0; b < CapW; b++)
      if (c[b]) n = NodeW'((MemUnits >> b) + (int'(s) >> b));
    return n;
  endfunction

  always_comb begin
    state_d = state_q; type_d = type_q; size_d = size_q; rid_d = rid_q;
    idc_d = idc_q; live_d = live_q; idx_d = idx_q; node_d = node_q; end_d = end_q;
    need_d = need_q; blk_d = blk_q; st_d = st_q; bid_d = bid_q; sa_d = sa_q;
    cap_d = cap_q;
    fm_we = 1'b0; fm_wa = node_q; fm_wd = 1'b0; fm_ra = node_q;
    tb_we = 1'b0; tb_wa = idx_q[LiveW-1:0]; tb_wd = tb_rd_q;
    tb_ra = idx_q[LiveW-1:0];
    case (state_q)
      S_CLR: begin
        // sweep the free map: only the root stays set
        fm_we = 1'b1; fm_wa = node_q; fm_wd = (node_q == NodeW'(1));
        node_d = node_q + 1'b1;
        if (node_q == NodeW'(TreeSlots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          type_d = req_type_i; size_d = {1'b0, req_size_i}; rid_d = req_id_i;
          st_d = StNotFound; bid_d = '0; sa_d = '0; cap_d = '0;
          idx_d = '0;
          case (req_type_i)
            ReqAlloc:  state_d = S_GRAB;
            ReqFree, ReqResize: state_d = S_FIND;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_FIND: begin
        if (idx_q >= live_q) state_d = S_DONE;
        else begin tb_ra = idx_q[LiveW-1:0]; state_d = S_FINDW; end
      end
      S_FINDW: begin
        if (tb_rd_q.id == rid_q) begin
          bid_d = tb_rd_q.id; sa_d = tb_rd_q.start; cap_d = tb_rd_q.cap;
          node_d = node_of(tb_rd_q.start, tb_rd_q.cap);
          if (type_q == ReqResize && size_q <= 17'(tb_rd_q.cap)) begin
            st_d = StOk; state_d = S_DONE;
          end else begin
            st_d = (type_q == ReqFree) ? StOk : StMoveFail;
            state_d = S_SHIFT;
          end
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_FIND;
        end
      end
      S_SHIFT: begin
        // move entry idx+1 down to idx
        if (idx_q + 1'b1 >= live_q) begin
          live_d = live_q - 1'b1; state_d = S_MSET;
        end else begin
          tb_ra = LiveW'(idx_q + 1'b1); state_d = S_SHIFW;
        end
      end
      S_SHIFW: begin
        tb_we = 1'b1; tb_wa = idx_q[LiveW-1:0]; tb_wd = tb_rd_q;
        idx_d = idx_q + 1'b1; state_d = S_SHIFT;
      end
      S_MSET: begin
        fm_we = 1'b1; fm_wa = node_q; fm_wd = 1'b1;
        fm_ra = node_q ^ NodeW'(1);
        state_d = S_MCHK;
        if (node_q <= NodeW'(1)) state_d = (type_q == ReqResize) ? S_GRAB : S_DONE;
      end
      S_MCHK: begin
        if (fm_rd_q) begin
          // clear the buddy now, the node itself next, then climb to parent
          fm_we = 1'b1; fm_wa = node_q ^ NodeW'(1); fm_wd = 1'b0;
          end_d = {1'b0, node_q};
          node_d = node_q >> 1;
          state_d = S_MCLR;
        end else begin
          state_d = (type_q == ReqResize) ? S_GRAB : S_DONE;
        end
      end
      S_MCLR: begin
        // clear the child that was set, then set the parent
        fm_we = 1'b1; fm_wa = end_q[NodeW-1:0]; fm_wd = 1'b0;
        state_d = S_MSET;
      end
      S_GRAB: begin
        if (live_q >= CntW'(MaxLive) || size_q > 17'(MemUnits)) begin
          state_d = S_DONE;
          if (type_q == ReqAlloc) st_d = StNoSpace;
          else begin sa_d = '0; cap_d = '0; end
        end else begin
          need_d = '0;
          for (int b = CapW - 1; b >= 0; b--)
            if (17'(1 << b) >= size_q) need_d = CapW'(1 << b);
          blk_d = need_d;
          node_d = NodeW'(MemUnits);
          for (int b = 0; b < CapW; b++)
            if (need_d[b]) node_d = NodeW'(MemUnits >> b);
          end_d = {node_d, 1'b0};
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        fm_ra = node_q; state_d = S_SRCHW;
      end
      S_SRCHW: begin
        if (fm_rd_q) begin
          fm_we = 1'b1; fm_wa = node_q; fm_wd = 1'b0;
          state_d = S_SPLIT;
        end else if ({1'b0, node_q} + 1'b1 == end_q) begin
          if (blk_q == MemCap) begin
            state_d = S_DONE;
            if (type_q == ReqAlloc) begin
              st_d = StNoSpace; bid_d = '0; sa_d = '0; cap_d = '0;
            end else begin sa_d = '0; cap_d = '0; end
          end else begin
            blk_d = blk_q << 1; node_d = NodeW'(end_q >> 2); end_d = end_q >> 1;
            state_d = S_SRCH;
          end
        end else begin
          node_d = node_q + 1'b1; state_d = S_SRCH;
        end
      end
      S_SPLIT: begin
        if (blk_q > need_q) begin
          blk_d = blk_q >> 1; node_d = node_q << 1;
          fm_we = 1'b1; fm_wa = (node_q << 1) | NodeW'(1); fm_wd = 1'b1;
        end else begin
          sa_d = AddrW'(32'(node_q) * 32'(need_q) - 32'(MemUnits));
          cap_d = need_q; bid_d = idc_q;
          st_d = (type_q == ReqAlloc) ? StOk : StMoved;
          tb_we = 1'b1; tb_wa = live_q[LiveW-1:0];
          tb_wd.id = idc_q;
          tb_wd.start = AddrW'(32'(node_q) * 32'(need_q) - 32'(MemUnits));
          tb_wd.cap = need_q;
          live_d = live_q + 1'b1; idc_d = idc_q + 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; node_q <= '0; live_q <= '0; idc_q <= '0;
    end else begin
      state_q <= state_d; node_q <= node_d; live_q <= live_d; idc_q <= idc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d; size_q <= size_d; rid_q <= rid_d; idx_q <= idx_d;
    end_q <= end_d; need_q <= need_d; blk_q <= blk_d; st_q <= st_d;
    bid_q <= bid_d; sa_q <= sa_d; cap_q <= cap_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign status_o     = st_q;
  assign block_id_o   = bid_q;
  assign base_addr_o  = sa_q;
  assign capacity_o   = cap_q;
endmodule
